/* hw/rtl/csp_pkg.sv */
// shared types and constants of the channel section parser
// used by the front, queue, back and top level modules
package csp_pkg;

    // result queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // reset value of the channel list descriptor tag
    localparam logic [7:0] TAG_RESET = 8'd177;

    // one channel list result
    typedef struct packed {
        logic [15:0] service_id;
        logic [5:0]  service_type;
        logic [15:0] channel_id;
        logic [15:0] stream_id;
        logic [15:0] network_id;
    } csp_record_t;

    // queue status seen by the top level input handshake and by the back
    typedef struct packed {
        logic full;
        logic not_empty;
    } csp_qstat_t;

    // descriptor length of a channel list: 2 region bytes and 1 to 28 whole 9-byte records
    function automatic logic chan_len_ok(input logic [7:0] len);
        logic ok;
        ok = 1'b0;
        for (int k = 1; k <= 28; k++) begin
            if (len == 8'(2 + 9 * k)) begin
                ok = 1'b1;
            end
        end
        return ok;
    endfunction

endpackage

/* hw/rtl/csp_front.sv */
// front part: byte-wise section parser, emits one record per channel entry
// depends on csp_pkg
module csp_front
    import csp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        push,
    output csp_record_t record
);

    // parse phases
    localparam logic [3:0] PH_HDR     = 4'd0;
    localparam logic [3:0] PH_D1_TAG  = 4'd1;
    localparam logic [3:0] PH_D1_LEN  = 4'd2;
    localparam logic [3:0] PH_D1_BODY = 4'd3;
    localparam logic [3:0] PH_TLEN    = 4'd4;
    localparam logic [3:0] PH_E_HDR   = 4'd5;
    localparam logic [3:0] PH_D2_TAG  = 4'd6;
    localparam logic [3:0] PH_D2_LEN  = 4'd7;
    localparam logic [3:0] PH_D2_BODY = 4'd8;
    localparam logic [3:0] PH_IGNORE  = 4'd9;

    // record byte index of the first region byte
    localparam logic [3:0] RIDX_REGION = 4'd14;

    logic [7:0]  tag_reg;
    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  offset_reg, offset_next;
    logic [11:0] sec_reg, sec_next;
    logic [11:0] outer_reg, outer_next;
    logic [11:0] entry_reg, entry_next;
    logic [7:0]  desc_reg, desc_next;
    logic        islist_reg, islist_next;
    logic [3:0]  ridx_reg, ridx_next;
    logic [39:0] fields_reg, fields_next;
    logic [15:0] sid_reg, sid_next;
    logic [15:0] nid_reg, nid_next;
    logic        emit;

    function automatic logic [11:0] dec12(input logic [11:0] v);
        return (v != 12'd0) ? v - 12'd1 : v;
    endfunction

    // phase after the first loop (header, first loop descriptors)
    function automatic logic [3:0] first_loop_phase(input logic [11:0] outer,
                                                    input logic [11:0] sec);
        logic [3:0] ph;
        if (outer == 12'd0) begin
            ph = (sec > 12'd1) ? PH_TLEN : PH_IGNORE;
        end else if (outer == 12'd1) begin
            ph = PH_IGNORE;
        end else begin
            ph = PH_D1_TAG;
        end
        return ph;
    endfunction

    // phase at the start of a transport entry
    function automatic logic [3:0] entry_phase(input logic [11:0] outer);
        return (outer > 12'd4) ? PH_E_HDR : PH_IGNORE;
    endfunction

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= TAG_RESET;
        end
        else if (cfg_write)
        begin
            tag_reg <= cfg_data;
        end
    end

    // next state of the parser
    always_comb
    begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        sec_next    = sec_reg;
        outer_next  = outer_reg;
        entry_next  = entry_reg;
        desc_next   = desc_reg;
        islist_next = islist_reg;
        ridx_next   = ridx_reg;
        fields_next = fields_reg;
        sid_next    = sid_reg;
        nid_next    = nid_reg;
        emit        = 1'b0;

        case (phase_reg)
            PH_HDR:
            begin
                if (offset_reg == 4'd1)
                begin
                    sec_next = {data_byte[3:0], 8'h00};
                end
                else if (offset_reg == 4'd2)
                begin
                    sec_next = sec_reg | {4'h0, data_byte};
                end
                else if (offset_reg == 4'd8)
                begin
                    outer_next = {data_byte[3:0], 8'h00};
                end
                if (offset_reg >= 4'd9)
                begin
                    outer_next = outer_reg | {4'h0, data_byte};
                    sec_next   = (sec_reg > 12'd11) ? sec_reg - 12'd11 : 12'd0;
                    if (sec_next < outer_next)
                    begin
                        phase_next = PH_IGNORE;
                    end
                    else
                    begin
                        phase_next  = first_loop_phase(outer_next, sec_next);
                        offset_next = 4'd0;
                    end
                end
                else
                begin
                    offset_next = offset_reg + 4'd1;
                end
            end
            PH_D1_TAG:
            begin
                outer_next = dec12(outer_reg);
                sec_next   = dec12(sec_reg);
                phase_next = PH_D1_LEN;
            end
            PH_D1_LEN:
            begin
                outer_next = dec12(outer_reg);
                sec_next   = dec12(sec_reg);
                if ({4'h0, data_byte} > outer_next)
                begin
                    phase_next = PH_IGNORE;
                end
                else
                begin
                    desc_next = data_byte;
                    if (data_byte == 8'd0)
                    begin
                        phase_next  = first_loop_phase(outer_next, sec_next);
                        offset_next = 4'd0;
                    end
                    else
                    begin
                        phase_next = PH_D1_BODY;
                    end
                end
            end
            PH_D1_BODY:
            begin
                outer_next = dec12(outer_reg);
                sec_next   = dec12(sec_reg);
                desc_next  = (desc_reg != 8'd0) ? desc_reg - 8'd1 : desc_reg;
                if (desc_next == 8'd0)
                begin
                    phase_next  = first_loop_phase(outer_next, sec_next);
                    offset_next = 4'd0;
                end
            end
            PH_TLEN:
            begin
                sec_next = dec12(sec_reg);
                if (offset_reg == 4'd0)
                begin
                    outer_next  = {data_byte[3:0], 8'h00};
                    offset_next = 4'd1;
                end
                else
                begin
                    outer_next = outer_reg | {4'h0, data_byte};
                    if (sec_next < outer_next)
                    begin
                        phase_next = PH_IGNORE;
                    end
                    else
                    begin
                        phase_next  = entry_phase(outer_next);
                        offset_next = 4'd0;
                    end
                end
            end
            PH_E_HDR:
            begin
                if (outer_reg == 12'd0)
                begin
                    phase_next = PH_IGNORE;
                end
                else
                begin
                    outer_next = dec12(outer_reg);
                    sec_next   = dec12(sec_reg);
                    case (offset_reg)
                        4'd0:    sid_next   = {data_byte, 8'h00};
                        4'd1:    sid_next   = sid_reg | {8'h00, data_byte};
                        4'd2:    nid_next   = {data_byte, 8'h00};
                        4'd3:    nid_next   = nid_reg | {8'h00, data_byte};
                        4'd4:    entry_next = {data_byte[3:0], 8'h00};
                        default: entry_next = entry_reg | {4'h0, data_byte};
                    endcase
                    if (offset_reg >= 4'd5)
                    begin
                        if (entry_next > outer_next)
                        begin
                            phase_next = PH_IGNORE;
                        end
                        else if (entry_next == 12'd0)
                        begin
                            phase_next  = entry_phase(outer_next);
                            offset_next = 4'd0;
                        end
                        else
                        begin
                            phase_next = PH_D2_TAG;
                        end
                    end
                    else
                    begin
                        offset_next = offset_reg + 4'd1;
                    end
                end
            end
            PH_D2_TAG:
            begin
                outer_next  = dec12(outer_reg);
                sec_next    = dec12(sec_reg);
                entry_next  = dec12(entry_reg);
                islist_next = (data_byte == tag_reg);
                if (entry_next == 12'd0)
                begin
                    phase_next  = entry_phase(outer_next);
                    offset_next = 4'd0;
                end
                else
                begin
                    phase_next = PH_D2_LEN;
                end
            end
            PH_D2_LEN:
            begin
                outer_next  = dec12(outer_reg);
                sec_next    = dec12(sec_reg);
                entry_next  = dec12(entry_reg);
                desc_next   = data_byte;
                islist_next = islist_reg && chan_len_ok(data_byte);
                ridx_next   = RIDX_REGION;
                fields_next = 40'd0;
                if (entry_next == 12'd0)
                begin
                    phase_next  = entry_phase(outer_next);
                    offset_next = 4'd0;
                end
                else if (data_byte == 8'd0)
                begin
                    phase_next = PH_D2_TAG;
                end
                else
                begin
                    phase_next = PH_D2_BODY;
                end
            end
            PH_D2_BODY:
            begin
                outer_next = dec12(outer_reg);
                sec_next   = dec12(sec_reg);
                entry_next = dec12(entry_reg);
                desc_next  = (desc_reg != 8'd0) ? desc_reg - 8'd1 : desc_reg;
                if (islist_reg)
                begin
                    if (ridx_reg < 4'd5)
                    begin
                        fields_next = {fields_reg[31:0], data_byte};
                    end
                    if (ridx_reg == 4'd8)
                    begin
                        emit        = 1'b1;
                        ridx_next   = 4'd0;
                        fields_next = 40'd0;
                    end
                    else
                    begin
                        ridx_next = ridx_reg + 4'd1;
                    end
                end
                if (entry_next == 12'd0)
                begin
                    phase_next  = entry_phase(outer_next);
                    offset_next = 4'd0;
                end
                else if (desc_next == 8'd0)
                begin
                    phase_next = PH_D2_TAG;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // parser state, back to the header phase after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR;
            offset_reg <= 4'd0;
            sec_reg    <= 12'd0;
            outer_reg  <= 12'd0;
            entry_reg  <= 12'd0;
            desc_reg   <= 8'd0;
            islist_reg <= 1'b0;
            ridx_reg   <= 4'd0;
            fields_reg <= 40'd0;
            sid_reg    <= 16'd0;
            nid_reg    <= 16'd0;
        end
        else if (accept && last_byte)
        begin
            phase_reg  <= PH_HDR;
            offset_reg <= 4'd0;
            sec_reg    <= 12'd0;
            outer_reg  <= 12'd0;
            entry_reg  <= 12'd0;
            desc_reg   <= 8'd0;
            islist_reg <= 1'b0;
            ridx_reg   <= 4'd0;
            fields_reg <= 40'd0;
            sid_reg    <= 16'd0;
            nid_reg    <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            sec_reg    <= sec_next;
            outer_reg  <= outer_next;
            entry_reg  <= entry_next;
            desc_reg   <= desc_next;
            islist_reg <= islist_next;
            ridx_reg   <= ridx_next;
            fields_reg <= fields_next;
            sid_reg    <= sid_next;
            nid_reg    <= nid_next;
        end
    end

    // record taken from the held entry bytes
    assign push                = accept && emit;
    assign record.service_id   = fields_reg[39:24];
    assign record.service_type = fields_reg[21:16];
    assign record.channel_id   = fields_reg[15:0];
    assign record.stream_id    = sid_reg;
    assign record.network_id   = nid_reg;

endmodule

/* hw/rtl/csp_queue.sv */
// short result queue between parser front and output back
// depends on csp_pkg
module csp_queue
    import csp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  csp_record_t push_data,
    input  logic        pop,
    output csp_record_t pop_data,
    output csp_qstat_t  status
);

    csp_record_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign pop_data         = slot_reg[rd_ptr_reg];
    assign status.full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.not_empty = (count_reg != '0);

endmodule

/* hw/rtl/csp_back.sv */
// back part: output register that hands records to the receiver
// depends on csp_pkg
module csp_back
    import csp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  csp_qstat_t  status,
    input  csp_record_t pop_data,
    output logic        pop,
    input  logic        result_stall,
    output logic        result_valid,
    output csp_record_t result
);

    logic        valid_reg;
    csp_record_t data_reg;

    // load a new record when the register is empty or being taken
    assign pop = status.not_empty && (!valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || !result_stall)
        begin
            valid_reg <= status.not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= pop_data;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

/* hw/rtl/channel_section_parser_unit.sv */
// Channel section parser: takes SI section bytes and emits logical channel records.
// The byte channel (byte_valid/byte_stall, data_byte, last_byte) carries one
// section byte per item, table id first; last_byte marks the final byte, after
// which the parser starts over at the section header.
// The result channel (result_valid/result_stall) carries one record per 9-byte
// entry of a channel list descriptor, with the ids of the enclosing transport entry.
// cfg_write/cfg_data set the channel list descriptor tag (177 after reset); write
// only while no records are in flight.
// Throughput: one byte per cycle while byte_stall is low; the parser updates its counters as each byte is accepted.
// A record is written to the queue as the byte completing it is accepted, then
// moves into the output register once that register is empty or being taken,
// and the receiver takes it from there.
// A four-entry queue sits between parser and output register; when it is full,
// byte_stall rises until the receiver takes a record. A stalled result holds.
// Reset (rst_n low) empties queue and output and puts the parser at the header.
// depends on csp_pkg, csp_front, csp_queue, csp_back
module channel_section_parser_unit
    import csp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] service_id,
    output logic [5:0]  service_type,
    output logic [15:0] channel_id,
    output logic [15:0] stream_id,
    output logic [15:0] network_id
);

    logic        accept;
    logic        push;
    logic        pop;
    csp_record_t push_data;
    csp_record_t pop_data;
    csp_record_t result;
    csp_qstat_t  status;

    // input handshake
    assign byte_stall = status.full;
    assign accept     = byte_valid && !status.full;

    csp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push),
        .record    (push_data)
    );

    csp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (status)
    );

    csp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .status       (status),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

    // result fields
    assign service_id   = result.service_id;
    assign service_type = result.service_type;
    assign channel_id   = result.channel_id;
    assign stream_id    = result.stream_id;
    assign network_id   = result.network_id;

endmodule

/* hw/rtl/csp_checker.sv */
// port-level checks of the channel section parser, bound to the top level
// depends on channel_section_parser_unit ports only
module csp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [15:0] service_id,
    input logic [5:0]  service_type,
    input logic [15:0] channel_id,
    input logic [15:0] stream_id,
    input logic [15:0] network_id
);

    // a stalled result holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(service_id)
            && $stable(service_type) && $stable(channel_id)
            && $stable(stream_id) && $stable(network_id))
        else $error("stalled result changed");

    // input stalls only while records are backed up at the output
    a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> result_valid)
        else $error("input stalled with empty output");

    // a new result burst follows an accepted byte (queue write, then output load)
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(byte_valid && !byte_stall, 2))
        else $error("result appeared without an accepted byte");

endmodule

bind channel_section_parser_unit csp_checker u_csp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .service_id   (service_id),
    .service_type (service_type),
    .channel_id   (channel_id),
    .stream_id    (stream_id),
    .network_id   (network_id)
);
